// File: sv/tts_pkg.sv
// Shared types, constants and helpers for the Tanimoto threshold screen.
package tts_pkg;

  localparam int WORD_BITS     = 64;
  localparam int IDX_W         = 5;
  localparam int ID_W          = 64;
  localparam int CNT_W         = 12;
  localparam int THR_W         = 31;
  localparam int PROD_W        = THR_W + CNT_W;
  localparam int MAX_WORDS_DEF = 32;
  localparam int WORDS_NARROW  = 4;
  localparam int WORDS_WIDE    = 32;
  localparam int WCNT_W        = $clog2(WORDS_WIDE + 1);
  localparam int CFG_ADDR_W    = 2;

  localparam logic [CNT_W-1:0] ACC_MAX = {CNT_W{1'b1}};

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WIDTH_SEL = 2'd0,
    REG_THR_NUM   = 2'd1,
    REG_THR_DEN   = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    ACT_QUERY = 1'b0,
    ACT_ROW   = 1'b1
  } action_t;

  typedef struct packed {
    logic first;
    logic last;
  } row_ctl_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] and_cnt;
    logic [CNT_W-1:0] or_cnt;
    logic             empty;
  } row_result_t;

  // words per fingerprint for the selected width, capped by the store depth
  function automatic int words_in_use(input int max_words, input logic width_select);
    int w;
    w = width_select ? WORDS_WIDE : WORDS_NARROW;
    return (w > max_words) ? max_words : w;
  endfunction

  function automatic logic [6:0] popcount64(input logic [WORD_BITS-1:0] x);
    logic [WORD_BITS-1:0] s1, s2, s3;
    logic [4:0] l1a, l1b, l1c, l1d;
    logic [5:0] l2a, l2b;
    s1  = x - ((x >> 1) & 64'h5555_5555_5555_5555);
    s2  = (s1 & 64'h3333_3333_3333_3333) + ((s1 >> 2) & 64'h3333_3333_3333_3333);
    s3  = (s2 + (s2 >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
    l1a = 5'(s3[7:0])   + 5'(s3[15:8]);
    l1b = 5'(s3[23:16]) + 5'(s3[31:24]);
    l1c = 5'(s3[39:32]) + 5'(s3[47:40]);
    l1d = 5'(s3[55:48]) + 5'(s3[63:56]);
    l2a = 6'(l1a) + 6'(l1b);
    l2b = 6'(l1c) + 6'(l1d);
    return 7'(l2a) + 7'(l2b);
  endfunction

endpackage

// File: sv/tanimoto_threshold_screen.sv
// Tanimoto threshold screen: input stage, config registers and pipeline top.
// A row's last word passes the input stage and the row result register into the output register.
// Throughput: one word per cycle; a row's last word held in the input stage blocks new words.
// Only a row's last word stalls, and only while the pending result and output registers are full.
// Reset (rst, synchronous, active high) empties the pipeline, zeroes the row sums and
// nonzero flags, and sets width_select to 1 and both threshold terms to 1.
module tanimoto_threshold_screen import tts_pkg::*; #(
  parameter int MAX_WORDS = MAX_WORDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [THR_W-1:0]      cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  action,
  input  logic [IDX_W-1:0]      word_index,
  input  logic [WORD_BITS-1:0]  data_word,
  input  logic [ID_W-1:0]       row_id,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ID_W-1:0]       result_id,
  output logic [CNT_W-1:0]      intersection,
  output logic [CNT_W-1:0]      union_total,
  output logic                  is_hit,
  output logic                  query_empty
);

  localparam int AW = $clog2(MAX_WORDS);
  localparam int CW = (AW > IDX_W) ? AW : IDX_W;

  logic                 width_select;
  logic [THR_W-1:0]     thr_num;
  logic [THR_W-1:0]     thr_den;

  logic                 accept;
  logic [CW-1:0]        idx_ext;
  logic [AW-1:0]        addr;
  logic [WCNT_W-1:0]    words;
  logic [WCNT_W-1:0]    idx_w;
  logic                 row_use;
  logic                 q_wr;
  row_ctl_t             ctl_in;

  logic                 s1_valid;
  row_ctl_t             s1_ctl;
  logic [WORD_BITS-1:0] s1_data;
  logic [ID_W-1:0]      s1_id;
  logic                 s1_take;

  logic [WORD_BITS-1:0] qword;
  logic                 qempty;
  logic                 r_valid;
  row_result_t          r;
  logic                 r_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_select <= 1'b1;
      thr_num      <= THR_W'(1);
      thr_den      <= THR_W'(1);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_WIDTH_SEL: width_select <= cfg_wdata[0];
        REG_THR_NUM:   thr_num      <= cfg_wdata;
        REG_THR_DEN:   thr_den      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ready = !s1_valid || s1_take;
  assign accept   = in_valid && in_ready;

  always_comb begin
    idx_ext      = CW'(word_index);
    addr         = idx_ext[AW-1:0];
    words        = WCNT_W'(words_in_use(MAX_WORDS, width_select));
    idx_w        = WCNT_W'(word_index);
    // row words past the fingerprint width are dropped
    row_use      = (action == ACT_ROW) && (idx_w < words);
    q_wr         = accept && (action == ACT_QUERY) && (int'(word_index) < MAX_WORDS);
    ctl_in.first = (word_index == '0);
    ctl_in.last  = (idx_w == words - WCNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= row_use;
    end else if (s1_take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && row_use) begin
      s1_ctl  <= ctl_in;
      s1_data <= data_word;
      s1_id   <= row_id;
    end
  end

  tts_query_store #(
    .MAX_WORDS (MAX_WORDS),
    .AW        (AW)
  ) u_store (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (q_wr),
    .rd_en        (accept && row_use),
    .addr         (addr),
    .wdata        (data_word),
    .width_select (width_select),
    .rd_word      (qword),
    .rd_empty     (qempty)
  );

  tts_accum u_accum (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1_ctl   (s1_ctl),
    .s1_data  (s1_data),
    .s1_id    (s1_id),
    .qword    (qword),
    .qempty   (qempty),
    .s1_take  (s1_take),
    .r_valid  (r_valid),
    .r        (r),
    .r_take   (r_take)
  );

  tts_threshold u_thr (
    .clk          (clk),
    .rst          (rst),
    .r_valid      (r_valid),
    .r            (r),
    .r_take       (r_take),
    .thr_num      (thr_num),
    .thr_den      (thr_den),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_id    (result_id),
    .intersection (intersection),
    .union_total  (union_total),
    .is_hit       (is_hit),
    .query_empty  (query_empty)
  );

  property p_stage_held;
    @(posedge clk) disable iff (rst)
      s1_valid && !s1_take |=> s1_valid && $stable(s1_data) && $stable(s1_ctl);
  endproperty
  a_stage_held: assert property (p_stage_held)
    else $error("stalled row word changed in the input stage");

endmodule

// File: sv/tts_query_store.sv
// Query fingerprint word store with per-word nonzero flags and registered read.
module tts_query_store import tts_pkg::*; #(
  parameter int MAX_WORDS = MAX_WORDS_DEF,
  parameter int AW        = $clog2(MAX_WORDS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic                 rd_en,
  input  logic [AW-1:0]        addr,
  input  logic [WORD_BITS-1:0] wdata,
  input  logic                 width_select,
  output logic [WORD_BITS-1:0] rd_word,
  output logic                 rd_empty
);

  logic [WORD_BITS-1:0] mem [MAX_WORDS];
  logic [MAX_WORDS-1:0] nz;
  logic [MAX_WORDS-1:0] nz_live;
  int                   words;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rd_word <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nz <= '0;
    end else if (wr_en) begin
      nz[addr] <= |wdata;
    end
  end

  // emptiness covers words 0..W-1 as they stand when the row word arrives
  always_comb begin
    words = words_in_use(MAX_WORDS, width_select);
    for (int i = 0; i < MAX_WORDS; i++) begin
      nz_live[i] = nz[i] && (i < words);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_empty <= ~|nz_live;
    end
  end

  property p_write_sets_flag;
    @(posedge clk) disable iff (rst)
      wr_en |=> (nz[$past(addr)] == (|$past(wdata)));
  endproperty
  a_write_sets_flag: assert property (p_write_sets_flag)
    else $error("nonzero flag does not follow the written query word");

endmodule

// File: sv/tts_accum.sv
// Popcount and saturating accumulation of AND/OR counts per database row.
module tts_accum import tts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s1_valid,
  input  row_ctl_t             s1_ctl,
  input  logic [WORD_BITS-1:0] s1_data,
  input  logic [ID_W-1:0]      s1_id,
  input  logic [WORD_BITS-1:0] qword,
  input  logic                 qempty,
  output logic                 s1_take,
  output logic                 r_valid,
  output row_result_t          r,
  input  logic                 r_take
);

  logic [CNT_W-1:0] acc_and;
  logic [CNT_W-1:0] acc_or;
  logic [CNT_W-1:0] base_and, base_or;
  logic [CNT_W:0]   sum_and, sum_or;
  logic [CNT_W-1:0] sat_and, sat_or;
  logic             r_free;

  assign r_free  = !r_valid || r_take;
  // only a row's last word needs room in the result register
  assign s1_take = s1_valid && (!s1_ctl.last || r_free);

  always_comb begin
    base_and = s1_ctl.first ? '0 : acc_and;
    base_or  = s1_ctl.first ? '0 : acc_or;
    sum_and  = {1'b0, base_and} + (CNT_W + 1)'(popcount64(s1_data & qword));
    sum_or   = {1'b0, base_or}  + (CNT_W + 1)'(popcount64(s1_data | qword));
    sat_and  = sum_and[CNT_W] ? ACC_MAX : sum_and[CNT_W-1:0];
    sat_or   = sum_or[CNT_W]  ? ACC_MAX : sum_or[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_and <= '0;
      acc_or  <= '0;
    end else if (s1_take) begin
      acc_and <= s1_ctl.last ? '0 : sat_and;
      acc_or  <= s1_ctl.last ? '0 : sat_or;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (s1_take && s1_ctl.last) begin
      r_valid <= 1'b1;
    end else if (r_take) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && s1_ctl.last) begin
      r.id      <= s1_id;
      r.and_cnt <= sat_and;
      r.or_cnt  <= sat_or;
      r.empty   <= qempty;
    end
  end

  property p_result_held;
    @(posedge clk) disable iff (rst)
      r_valid && !r_take |=> r_valid && $stable(r);
  endproperty
  a_result_held: assert property (p_result_held)
    else $error("pending row result changed before it was taken");

  property p_and_within_or;
    @(posedge clk) disable iff (rst)
      r_valid |-> r.and_cnt <= r.or_cnt;
  endproperty
  a_and_within_or: assert property (p_and_within_or)
    else $error("intersection count exceeds union count");

endmodule

// File: sv/tts_threshold.sv
// Threshold compare n*intersection >= m*union into the output register.
module tts_threshold import tts_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              r_valid,
  input  row_result_t       r,
  output logic              r_take,
  input  logic [THR_W-1:0]  thr_num,
  input  logic [THR_W-1:0]  thr_den,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ID_W-1:0]   result_id,
  output logic [CNT_W-1:0]  intersection,
  output logic [CNT_W-1:0]  union_total,
  output logic              is_hit,
  output logic              query_empty
);

  logic              out_free;
  logic [PROD_W-1:0] prod_n, prod_m;
  logic              hit;

  assign out_free = !out_valid || out_ready;
  assign r_take   = r_valid && out_free;

  always_comb begin
    prod_n = PROD_W'(thr_den) * PROD_W'(r.and_cnt);
    prod_m = PROD_W'(thr_num) * PROD_W'(r.or_cnt);
    hit    = !r.empty && (prod_n >= prod_m);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r_take) begin
      result_id    <= r.id;
      intersection <= r.and_cnt;
      union_total  <= r.or_cnt;
      is_hit       <= hit;
      query_empty  <= r.empty;
    end
  end

  property p_no_hit_on_empty;
    @(posedge clk) disable iff (rst)
      out_valid && query_empty |-> !is_hit;
  endproperty
  a_no_hit_on_empty: assert property (p_no_hit_on_empty)
    else $error("hit reported for an empty query");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for tanimoto_threshold_screen: directed and random word traffic checked against a scoreboard.
module tb_top;
  import tts_pkg::*;

  localparam int STORE_WORDS   = 32;
  localparam int SAT_LEVEL     = 4095;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT   = 600000;

  typedef struct {
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] inter_cnt;
    logic [CNT_W-1:0] union_cnt;
    logic             hit;
    logic             empty;
  } row_score_t;

  typedef enum int {RK_ZERO, RK_ONES, RK_COPY, RK_NEAR, RK_PART, RK_RANDOM} row_kind_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [THR_W-1:0]      cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  action_t               action;
  logic [IDX_W-1:0]      word_index;
  logic [WORD_BITS-1:0]  data_word;
  logic [ID_W-1:0]       row_id;
  logic                  out_valid;
  logic                  out_ready;
  logic [ID_W-1:0]       result_id;
  logic [CNT_W-1:0]      intersection;
  logic [CNT_W-1:0]      union_total;
  logic                  is_hit;
  logic                  query_empty;

  // predictor state
  logic [WORD_BITS-1:0] q_words [STORE_WORDS];
  int unsigned          and_sum;
  int unsigned          or_sum;
  logic                 width_sel;
  logic [THR_W-1:0]     thr_num;
  logic [THR_W-1:0]     thr_den;
  row_score_t           row_results_due[$];

  int  words_used;
  int  err_count;
  int  cycle_count;
  bit  quiet;
  int  gap_pct;

  tanimoto_threshold_screen #(.MAX_WORDS(STORE_WORDS)) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .word_index  (word_index),
    .data_word   (data_word),
    .row_id      (row_id),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_id   (result_id),
    .intersection(intersection),
    .union_total (union_total),
    .is_hit      (is_hit),
    .query_empty (query_empty)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned fp_words();
    int unsigned w;
    w = width_sel ? WORDS_WIDE : WORDS_NARROW;
    return (w > STORE_WORDS) ? STORE_WORDS : w;
  endfunction

  function automatic int unsigned sat_add(int unsigned acc, int unsigned v);
    return (acc + v > SAT_LEVEL) ? SAT_LEVEL : acc + v;
  endfunction

  // one accepted word: store a query word, or update sums and queue a score on the row's last word
  function automatic void screen_word(action_t act, logic [IDX_W-1:0] idx,
                                      logic [WORD_BITS-1:0] data, logic [ID_W-1:0] id);
    int unsigned          w;
    logic [WORD_BITS-1:0] any;
    longint unsigned      lhs;
    longint unsigned      rhs;
    row_score_t           r;
    w = fp_words();
    if (act == ACT_QUERY) begin
      if (idx < STORE_WORDS) q_words[idx] = data;
      words_used++;
      return;
    end
    if (idx >= w) return;
    words_used++;
    if (idx == 0) begin
      and_sum = 0;
      or_sum = 0;
    end
    and_sum = sat_add(and_sum, $countones(data & q_words[idx]));
    or_sum = sat_add(or_sum, $countones(data | q_words[idx]));
    if (idx != w - 1) return;
    any = '0;
    for (int i = 0; i < w; i++) any |= q_words[i];
    lhs = 64'(thr_den) * 64'(and_sum);
    rhs = 64'(thr_num) * 64'(or_sum);
    r.id = id;
    r.inter_cnt = CNT_W'(and_sum);
    r.union_cnt = CNT_W'(or_sum);
    r.empty = (any == '0);
    r.hit = (any != '0) && (lhs >= rhs);
    row_results_due = {row_results_due, r};
    and_sum = 0;
    or_sum = 0;
  endfunction

  function automatic logic [WORD_BITS-1:0] query_bits();
    logic [WORD_BITS-1:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return r & {$urandom, $urandom} & {$urandom, $urandom};
      default: return r;
    endcase
  endfunction

  function automatic logic [WORD_BITS-1:0] row_bits(row_kind_t kind, logic [IDX_W-1:0] idx);
    logic [WORD_BITS-1:0] r;
    r = {$urandom, $urandom};
    case (kind)
      RK_ZERO: return '0;
      RK_ONES: return '1;
      RK_COPY: return q_words[idx];
      RK_NEAR: return q_words[idx] ^ (64'd1 << $urandom_range(0, 63));
      RK_PART: return q_words[idx] & r;
      default: return r;
    endcase
  endfunction

  task automatic put_word(action_t act, logic [IDX_W-1:0] idx,
                          logic [WORD_BITS-1:0] data, logic [ID_W-1:0] id);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    word_index <= idx;
    data_word  <= data;
    row_id     <= id;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    screen_word(act, idx, data, id);
  endtask

  // mixed rows pick each word's pattern at random, may stop early and may reload
  // a query word in the middle
  task automatic send_row(row_kind_t kind, bit mixed, logic [ID_W-1:0] id);
    int unsigned w;
    int unsigned stop;
    row_kind_t   wk;
    w = fp_words();
    stop = (mixed && $urandom_range(0, 9) == 0) ? $urandom_range(0, w - 1) : w;
    for (int k = 0; k < stop; k++) begin
      if (mixed && $urandom_range(0, 24) == 0)
        put_word(ACT_QUERY, IDX_W'($urandom_range(0, STORE_WORDS - 1)), query_bits(),
                 {$urandom, $urandom});
      wk = mixed ? row_kind_t'($urandom_range(0, 5)) : kind;
      put_word(ACT_ROW, IDX_W'(k), row_bits(wk, IDX_W'(k)),
               (k == w - 1) ? id : {$urandom, $urandom});
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (row_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic ws, logic [THR_W-1:0] m, logic [THR_W-1:0] n);
    settle();
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_WIDTH_SEL;
    cfg_wdata <= THR_W'(ws);
    @(posedge clk);
    width_sel = ws;
    cfg_addr  <= REG_THR_NUM;
    cfg_wdata <= m;
    @(posedge clk);
    thr_num = m;
    cfg_addr  <= REG_THR_DEN;
    cfg_wdata <= n;
    @(posedge clk);
    thr_den = n;
    cfg_we <= 1'b0;
  endtask

  // full query load at reset settings (wide, m = n = 1)
  task automatic test_reset_values();
    for (int k = 0; k < STORE_WORDS; k++)
      put_word(ACT_QUERY, IDX_W'(k),
               (k == 0) ? '1 : (k == STORE_WORDS - 1) ? 64'h8000_0000_0000_0001
                                                      : {$urandom, $urandom},
               {$urandom, $urandom});
    send_row(RK_COPY, 1'b0, '1);
    send_row(RK_ZERO, 1'b0, '0);
  endtask

  task automatic test_narrow_width();
    configure(1'b0, 1, 1);
    send_row(RK_ONES, 1'b0, 64'h0123_4567_89AB_CDEF);
    put_word(ACT_ROW, 0, {$urandom, $urandom}, '0);
    // indexes past the fingerprint width are dropped
    put_word(ACT_ROW, 4, '1, '0);
    put_word(ACT_ROW, 31, '1, '0);
    put_word(ACT_ROW, 1, {$urandom, $urandom}, '0);
    put_word(ACT_ROW, 2, {$urandom, $urandom}, '0);
    put_word(ACT_ROW, 3, {$urandom, $urandom}, 64'hFEDC_BA98_7654_3210);
    send_row(RK_NEAR, 1'b0, {$urandom, $urandom});
  endtask

  task automatic test_threshold_extremes();
    logic [THR_W-1:0] nums [8];
    logic [THR_W-1:0] dens [8];
    nums = '{'1, 1, 0, 5, 0, 7, '1, 2};
    dens = '{1, '1, 5, 0, 0, 3, '1, 3};
    for (int i = 0; i < 8; i++) begin
      configure(1'b0, nums[i], dens[i]);
      send_row(RK_NEAR, 1'b0, {$urandom, $urandom});
      send_row(RK_COPY, 1'b0, {$urandom, $urandom});
    end
  endtask

  task automatic test_empty_query();
    configure(1'b0, 0, 1);
    for (int k = 0; k < WORDS_NARROW; k++) put_word(ACT_QUERY, IDX_W'(k), '0, '1);
    send_row(RK_RANDOM, 1'b0, {$urandom, $urandom});
    send_row(RK_ONES, 1'b0, {$urandom, $urandom});
    // upper words are still set, so the wide query is not empty
    configure(1'b1, 0, 1);
    send_row(RK_RANDOM, 1'b0, {$urandom, $urandom});
    configure(1'b0, 1, 1);
    for (int k = 0; k < WORDS_NARROW; k++)
      put_word(ACT_QUERY, IDX_W'(k), {$urandom, $urandom}, '0);
    send_row(RK_PART, 1'b0, {$urandom, $urandom});
  endtask

  task automatic test_midrow_reload();
    configure(1'b0, 1, 2);
    put_word(ACT_ROW, 0, {$urandom, $urandom}, '0);
    put_word(ACT_ROW, 1, {$urandom, $urandom}, '0);
    put_word(ACT_QUERY, 2, {$urandom, $urandom}, '0);
    put_word(ACT_QUERY, 0, {$urandom, $urandom}, '0);
    put_word(ACT_ROW, 2, {$urandom, $urandom}, '0);
    put_word(ACT_ROW, 3, {$urandom, $urandom}, {$urandom, $urandom});
  endtask

  task automatic test_out_of_order();
    configure(1'b0, 1, 1);
    put_word(ACT_ROW, 1, {$urandom, $urandom}, '0);
    put_word(ACT_ROW, 2, {$urandom, $urandom}, '0);
    put_word(ACT_ROW, 1, {$urandom, $urandom}, '0);
    put_word(ACT_ROW, 3, {$urandom, $urandom}, {$urandom, $urandom});
    put_word(ACT_ROW, 2, '1, '0);
    put_word(ACT_ROW, 0, {$urandom, $urandom}, '0);
    put_word(ACT_ROW, 3, {$urandom, $urandom}, {$urandom, $urandom});
    // repeated word pushes both sums past the counter range
    configure(1'b1, 1, 1);
    put_word(ACT_QUERY, 7, '1, '0);
    repeat (70) put_word(ACT_ROW, 7, '1, '0);
    put_word(ACT_ROW, 31, '1, {$urandom, $urandom});
    send_row(RK_COPY, 1'b0, {$urandom, $urandom});
  endtask

  task automatic test_random_traffic(int target, bit calm);
    int               start;
    logic             ws;
    logic [THR_W-1:0] m;
    logic [THR_W-1:0] n;
    start = words_used;
    while (words_used - start < target) begin
      ws = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 3))
        0: begin
          n = THR_W'($urandom_range(1, 12));
          m = THR_W'($urandom_range(1, n));
        end
        1: begin
          n = THR_W'($urandom);
          m = n;
        end
        2: begin
          m = THR_W'($urandom);
          n = THR_W'($urandom);
        end
        default: begin
          n = THR_W'($urandom_range(1, 4));
          m = THR_W'($urandom_range(0, 8));
        end
      endcase
      configure(ws, m, n);
      quiet = calm;
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 20;
        default: gap_pct = 50;
      endcase
      repeat (ws ? $urandom_range(2, 5) : $urandom_range(8, 30)) begin
        if ($urandom_range(0, 6) == 0)
          put_word(action_t'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 31)),
                   {$urandom, $urandom}, {$urandom, $urandom});
        else
          send_row(RK_RANDOM, 1'b1, {$urandom, $urandom});
      end
    end
  endtask

  // result side: ready in runs broken by stalls, with no stalls once quiet
  initial begin
    forever begin
      if (quiet || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        repeat (($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 20)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    row_score_t want;
    if (!rst && out_valid && out_ready) begin
      if (row_results_due.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result word, id %0h", $time, result_id);
      end else begin
        want = row_results_due.pop_front();
        check_field("result_id", want.id, result_id);
        check_field("intersection", 64'(want.inter_cnt), 64'(intersection));
        check_field("union_total", 64'(want.union_cnt), 64'(union_total));
        check_field("is_hit", 64'(want.hit), 64'(is_hit));
        check_field("query_empty", 64'(want.empty), 64'(query_empty));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tanimoto_threshold_screen test failed");
      $finish;
    end
  end

  initial begin
    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_addr   <= REG_WIDTH_SEL;
    cfg_wdata  <= '0;
    in_valid   <= 1'b0;
    action     <= ACT_QUERY;
    word_index <= '0;
    data_word  <= '0;
    row_id     <= '0;
    foreach (q_words[i]) q_words[i] = '0;
    and_sum     = 0;
    or_sum      = 0;
    width_sel   = 1'b1;
    thr_num     = 1;
    thr_den     = 1;
    words_used  = 0;
    err_count   = 0;
    cycle_count = 0;
    quiet       = 1'b0;
    gap_pct     = 30;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_narrow_width();
    test_threshold_extremes();
    test_empty_query();
    test_midrow_reload();
    test_out_of_order();
    test_random_traffic(650, 1'b0);
    test_random_traffic(180, 1'b1);
    settle();
    if (row_results_due.size() != 0) begin
      err_count++;
      $display("%0t: %0d expected results never arrived", $time, row_results_due.size());
    end
    if (err_count == 0)
      $display("tanimoto_threshold_screen test passed");
    else
      $display("tanimoto_threshold_screen test failed");
    $finish;
  end

endmodule
